/* design/spf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package spf_pkg;

   localparam int WORD_BITS      = 32;
   localparam int FRAC_BITS      = 16;
   localparam int CFG_BITS       = 31;
   localparam int DIR_BITS       = 18;
   localparam int QUO_BITS       = WORD_BITS - 1;
   localparam int CSR_INDEX_BITS = 3;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [DIR_BITS-1:0]  dir_type;
   typedef logic        [CFG_BITS-1:0]  cfg_type;
   typedef logic        [QUO_BITS-1:0]  quo_type;

   localparam cfg_type  CFG_ONE  = CFG_BITS'(1) << FRAC_BITS;
   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MASS_I,
      CSR_MASS_J,
      CSR_INV_MASS_I,
      CSR_INV_MASS_J,
      CSR_VISC_I,
      CSR_VISC_J
   } csr_index_type;

   // request fields carried alongside the dividers
   typedef struct packed {
      logic     live;
      logic     fault;
      word_type ux;
      word_type uy;
      word_type pi;
      word_type pj;
      word_type kg;
      dir_type  ex;
      dir_type  ey;
      cfg_type  r;
   } side_type;

   typedef struct packed {
      logic     live;
      logic     fault;
      word_type vi2;
      word_type vj2;
      word_type neta;
      word_type exk;
      word_type eyk;
      word_type pi;
      word_type pj;
      word_type kg;
      word_type r;
      word_type ux;
      word_type uy;
   } s1_type;

   typedef struct packed {
      logic     live;
      logic     fault;
      word_type s2;
      word_type ppi;
      word_type ppj;
      word_type ak;
      word_type exr;
      word_type eyr;
      word_type ux;
      word_type uy;
   } s2_type;

   typedef struct packed {
      logic     live;
      logic     fault;
      word_type pv;
      word_type vk;
      word_type exr;
      word_type eyr;
      word_type ux;
      word_type uy;
   } s3_type;

   typedef struct packed {
      logic     live;
      logic     fault;
      word_type tx;
      word_type ty;
      word_type qx;
      word_type qy;
   } s4_type;

   typedef struct packed {
      logic     live;
      logic     fault;
      word_type dx;
      word_type dy;
   } s5_type;

   typedef struct packed {
      logic     live;
      logic     fault;
      word_type aix;
      word_type aiy;
      word_type ajx;
      word_type ajy;
   } s6_type;

   typedef struct packed {
      word_type acc_i_x;
      word_type acc_i_y;
      word_type acc_j_x;
      word_type acc_j_y;
      logic     fault;
   } rsp_type;

   // exact product, floor shift, saturate
   function automatic word_type fmul(input word_type a, input word_type b);
      logic signed [2*WORD_BITS-1:0] prod;
      logic signed [2*WORD_BITS-1:0] shr;
      prod = (2*WORD_BITS)'(a) * (2*WORD_BITS)'(b);
      shr  = prod >>> FRAC_BITS;
      if ((&shr[2*WORD_BITS-1:WORD_BITS-1]) || !(|shr[2*WORD_BITS-1:WORD_BITS-1]))
         return shr[WORD_BITS-1:0];
      else if (shr[2*WORD_BITS-1])
         return WORD_MIN;
      else
         return WORD_MAX;
   endfunction

   function automatic word_type sat_add(input word_type a, input word_type b);
      logic [WORD_BITS:0] s;
      s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
      if (s[WORD_BITS] != s[WORD_BITS-1])
         return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
      return s[WORD_BITS-1:0];
   endfunction

   function automatic word_type sat_neg(input word_type a);
      if (a == WORD_MIN)
         return WORD_MAX;
      return -a;
   endfunction

endpackage

`default_nettype wire

/* design/sph_pair_force_unit.sv */
// Pair force unit for 2D multiphase SPH, Q16.16 fixed point.
// Request channel (req_valid / req_stall): one particle pair per request with
// densities, pressures, velocity difference, kernel gradient, unit direction
// and distance. Response channel (rsp_valid / rsp_stall): acceleration
// increments for both particles plus a fault flag for a zero density or a
// zero viscosity sum. The user writes material masses, inverse masses and
// viscosities via csr_ while no request is in flight; this is not enforced.
// Throughput: one request per cycle while req_stall is low. Pipeline: one
// input stage, 32 stages of the volume and viscosity dividers (a load
// stage, then one quotient bit per stage), six multiply / add stages and
// the output register.
// The response side has an output register and one skid entry; the pipeline
// keeps advancing while either is free and freezes only when both hold a
// response and rsp_stall is high, so req_stall then rises.
// Reset clears all valid bits and sets every material register to 1.0.
`timescale 1ns / 1ps
`default_nettype none

module sph_pair_force_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                csr_write,
   input  wire logic [spf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [spf_pkg::CFG_BITS-1:0]        csr_wdata,

   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_pair_interacts,
   input  wire logic        [30:0]                  req_rho_i,
   input  wire logic        [30:0]                  req_rho_j,
   input  wire logic signed [31:0]                  req_vel_diff_x,
   input  wire logic signed [31:0]                  req_vel_diff_y,
   input  wire logic signed [31:0]                  req_pres_i,
   input  wire logic signed [31:0]                  req_pres_j,
   input  wire logic signed [31:0]                  req_kernel_grad,
   input  wire logic signed [17:0]                  req_dir_x,
   input  wire logic signed [17:0]                  req_dir_y,
   input  wire logic        [30:0]                  req_distance,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [31:0]                       rsp_acc_i_x,
   output logic signed [31:0]                       rsp_acc_i_y,
   output logic signed [31:0]                       rsp_acc_j_x,
   output logic signed [31:0]                       rsp_acc_j_y,
   output logic                                     rsp_fault
);

   localparam int W          = spf_pkg::WORD_BITS;
   localparam int F          = spf_pkg::FRAC_BITS;
   localparam int CB         = spf_pkg::CFG_BITS;
   localparam int DB         = spf_pkg::DIR_BITS;
   localparam int DIV_LAT    = spf_pkg::QUO_BITS + 1;
   localparam int NUM_STAGES = 1 + DIV_LAT + 6;
   localparam int VOL_NUM_W  = CB + F;
   localparam int ETA_NUM_W  = 2 * CB + 1;
   localparam int ETA_DEN_W  = CB + 1;

   // material registers
   spf_pkg::cfg_type mass_i_ff, mass_j_ff, inv_mass_i_ff, inv_mass_j_ff;
   spf_pkg::cfg_type visc_i_ff, visc_j_ff;

   // flow control
   logic                  adv;
   logic                  pop;
   logic                  push;
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;

   // input stage
   spf_pkg::side_type      side_in;
   spf_pkg::side_type      side_ff [0:DIV_LAT];
   logic [ETA_DEN_W-1:0]   vsum;
   logic                   bad;
   logic [2*CB-1:0]        visc_prod;
   spf_pkg::cfg_type       p0_rho_i_ff, p0_rho_j_ff;
   logic [ETA_DEN_W-1:0]   p0_vsum_ff;
   logic [ETA_NUM_W-1:0]   p0_eta_num_ff;

   // divider results
   spf_pkg::quo_type vi_q, vj_q, eta_q;

   // arithmetic stages
   spf_pkg::word_type vi_w, vj_w, eta_w, ex_w, ey_w;
   spf_pkg::s1_type   s1_in, s1_ff;
   spf_pkg::s2_type   s2_in, s2_ff;
   spf_pkg::s3_type   s3_in, s3_ff;
   spf_pkg::s4_type   s4_in, s4_ff;
   spf_pkg::s5_type   s5_in, s5_ff;
   spf_pkg::s6_type   s6_in, s6_ff;

   // response buffer
   spf_pkg::rsp_type  res;
   spf_pkg::rsp_type  out_ff, out_in;
   spf_pkg::rsp_type  skid_ff, skid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              skid_valid_ff, skid_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_i_ff     <= spf_pkg::CFG_ONE;
         mass_j_ff     <= spf_pkg::CFG_ONE;
         inv_mass_i_ff <= spf_pkg::CFG_ONE;
         inv_mass_j_ff <= spf_pkg::CFG_ONE;
         visc_i_ff     <= spf_pkg::CFG_ONE;
         visc_j_ff     <= spf_pkg::CFG_ONE;
      end else if (csr_write) begin
         case (spf_pkg::csr_index_type'(csr_index))
            spf_pkg::CSR_MASS_I:     mass_i_ff     <= csr_wdata;
            spf_pkg::CSR_MASS_J:     mass_j_ff     <= csr_wdata;
            spf_pkg::CSR_INV_MASS_I: inv_mass_i_ff <= csr_wdata;
            spf_pkg::CSR_INV_MASS_J: inv_mass_j_ff <= csr_wdata;
            spf_pkg::CSR_VISC_I:     visc_i_ff     <= csr_wdata;
            spf_pkg::CSR_VISC_J:     visc_j_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // the pipeline moves unless both response slots are full and stalled
   assign adv       = !skid_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign pop       = rsp_valid_ff && !rsp_stall;
   assign push      = adv && vld_ff[NUM_STAGES-1];
   assign vld_in    = {vld_ff[NUM_STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // input stage
   assign vsum      = {1'b0, visc_i_ff} + {1'b0, visc_j_ff};
   assign bad       = (req_rho_i == '0) || (req_rho_j == '0) || (vsum == '0);
   assign visc_prod = (2*CB)'(visc_i_ff) * (2*CB)'(visc_j_ff);

   always_comb begin
      side_in       = '0;
      side_in.live  = req_pair_interacts && !bad;
      side_in.fault = req_pair_interacts && bad;
      side_in.ux    = req_vel_diff_x;
      side_in.uy    = req_vel_diff_y;
      side_in.pi    = req_pres_i;
      side_in.pj    = req_pres_j;
      side_in.kg    = req_kernel_grad;
      side_in.ex    = req_dir_x;
      side_in.ey    = req_dir_y;
      side_in.r     = req_distance;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0]    <= side_in;
         p0_rho_i_ff   <= req_rho_i;
         p0_rho_j_ff   <= req_rho_j;
         p0_vsum_ff    <= vsum;
         p0_eta_num_ff <= {visc_prod, 1'b0};
         for (int k = 1; k <= DIV_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   spf_div #(
      .NUM_W(VOL_NUM_W),
      .DEN_W(CB)
   ) u_div_vi (
      .clock(clock),
      .en   (adv),
      .num  ({mass_i_ff, {F{1'b0}}}),
      .den  (p0_rho_i_ff),
      .quo  (vi_q)
   );

   spf_div #(
      .NUM_W(VOL_NUM_W),
      .DEN_W(CB)
   ) u_div_vj (
      .clock(clock),
      .en   (adv),
      .num  ({mass_j_ff, {F{1'b0}}}),
      .den  (p0_rho_j_ff),
      .quo  (vj_q)
   );

   spf_div #(
      .NUM_W(ETA_NUM_W),
      .DEN_W(ETA_DEN_W)
   ) u_div_eta (
      .clock(clock),
      .en   (adv),
      .num  (p0_eta_num_ff),
      .den  (p0_vsum_ff),
      .quo  (eta_q)
   );

   assign vi_w  = {1'b0, vi_q};
   assign vj_w  = {1'b0, vj_q};
   assign eta_w = {1'b0, eta_q};
   assign ex_w  = {{(W-DB){side_ff[DIV_LAT].ex[DB-1]}}, side_ff[DIV_LAT].ex};
   assign ey_w  = {{(W-DB){side_ff[DIV_LAT].ey[DB-1]}}, side_ff[DIV_LAT].ey};

   // squared volumes, -eta, e*F
   always_comb begin
      s1_in.live  = side_ff[DIV_LAT].live;
      s1_in.fault = side_ff[DIV_LAT].fault;
      s1_in.vi2   = spf_pkg::fmul(vi_w, vi_w);
      s1_in.vj2   = spf_pkg::fmul(vj_w, vj_w);
      s1_in.neta  = spf_pkg::sat_neg(eta_w);
      s1_in.exk   = spf_pkg::fmul(ex_w, side_ff[DIV_LAT].kg);
      s1_in.eyk   = spf_pkg::fmul(ey_w, side_ff[DIV_LAT].kg);
      s1_in.pi    = side_ff[DIV_LAT].pi;
      s1_in.pj    = side_ff[DIV_LAT].pj;
      s1_in.kg    = side_ff[DIV_LAT].kg;
      s1_in.r     = {1'b0, side_ff[DIV_LAT].r};
      s1_in.ux    = side_ff[DIV_LAT].ux;
      s1_in.uy    = side_ff[DIV_LAT].uy;
   end

   always_comb begin
      s2_in.live  = s1_ff.live;
      s2_in.fault = s1_ff.fault;
      s2_in.s2    = spf_pkg::sat_add(s1_ff.vi2, s1_ff.vj2);
      s2_in.ppi   = spf_pkg::fmul(s1_ff.pi, s1_ff.vi2);
      s2_in.ppj   = spf_pkg::fmul(s1_ff.pj, s1_ff.vj2);
      s2_in.ak    = spf_pkg::fmul(s1_ff.neta, s1_ff.kg);
      s2_in.exr   = spf_pkg::fmul(s1_ff.exk, s1_ff.r);
      s2_in.eyr   = spf_pkg::fmul(s1_ff.eyk, s1_ff.r);
      s2_in.ux    = s1_ff.ux;
      s2_in.uy    = s1_ff.uy;
   end

   always_comb begin
      s3_in.live  = s2_ff.live;
      s3_in.fault = s2_ff.fault;
      s3_in.pv    = spf_pkg::sat_add(s2_ff.ppi, s2_ff.ppj);
      s3_in.vk    = spf_pkg::fmul(s2_ff.ak, s2_ff.s2);
      s3_in.exr   = s2_ff.exr;
      s3_in.eyr   = s2_ff.eyr;
      s3_in.ux    = s2_ff.ux;
      s3_in.uy    = s2_ff.uy;
   end

   always_comb begin
      s4_in.live  = s3_ff.live;
      s4_in.fault = s3_ff.fault;
      s4_in.tx    = spf_pkg::fmul(s3_ff.vk, s3_ff.ux);
      s4_in.ty    = spf_pkg::fmul(s3_ff.vk, s3_ff.uy);
      s4_in.qx    = spf_pkg::fmul(s3_ff.exr, s3_ff.pv);
      s4_in.qy    = spf_pkg::fmul(s3_ff.eyr, s3_ff.pv);
   end

   always_comb begin
      s5_in.live  = s4_ff.live;
      s5_in.fault = s4_ff.fault;
      s5_in.dx    = spf_pkg::sat_add(s4_ff.tx, s4_ff.qx);
      s5_in.dy    = spf_pkg::sat_add(s4_ff.ty, s4_ff.qy);
   end

   always_comb begin
      s6_in.live  = s5_ff.live;
      s6_in.fault = s5_ff.fault;
      s6_in.aix   = spf_pkg::fmul(s5_ff.dx, {1'b0, inv_mass_i_ff});
      s6_in.aiy   = spf_pkg::fmul(s5_ff.dy, {1'b0, inv_mass_i_ff});
      s6_in.ajx   = spf_pkg::fmul(s5_ff.dx, {1'b0, inv_mass_j_ff});
      s6_in.ajy   = spf_pkg::fmul(s5_ff.dy, {1'b0, inv_mass_j_ff});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
      end
   end

   // non-interacting or faulted pairs give zero increments
   always_comb begin
      res       = '0;
      res.fault = s6_ff.fault;
      if (s6_ff.live) begin
         res.acc_i_x = s6_ff.aix;
         res.acc_i_y = s6_ff.aiy;
         res.acc_j_x = spf_pkg::sat_neg(s6_ff.ajx);
         res.acc_j_y = spf_pkg::sat_neg(s6_ff.ajy);
      end
   end

   // output register plus one skid entry
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in = skid_ff;
            if (push) begin
               skid_in = res;
            end else begin
               skid_valid_in = 1'b0;
            end
         end
      end else if (rsp_valid_ff) begin
         if (push && pop) begin
            out_in = res;
         end else if (push) begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end else if (pop) begin
            rsp_valid_in = 1'b0;
         end
      end else if (push) begin
         out_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_acc_i_x = out_ff.acc_i_x;
   assign rsp_acc_i_y = out_ff.acc_i_y;
   assign rsp_acc_j_x = out_ff.acc_j_x;
   assign rsp_acc_j_y = out_ff.acc_j_y;
   assign rsp_fault   = out_ff.fault;

endmodule

`default_nettype wire

/* design/spf_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module spf_div #(
   parameter int NUM_W = 47,
   parameter int DEN_W = 31
) (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic [NUM_W-1:0]             num,
   input  wire logic [DEN_W-1:0]             den,
   output logic      [spf_pkg::QUO_BITS-1:0] quo
);

   localparam int QW    = spf_pkg::QUO_BITS;
   localparam int HI_W  = NUM_W - QW;
   localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

   logic [CMP_W-1:0] hi_ext;
   logic [CMP_W-1:0] den_ext;

   logic [DEN_W-1:0] rem_ff  [0:QW];
   logic [QW-1:0]    numq_ff [0:QW];
   logic [DEN_W-1:0] den_ff  [0:QW-1];
   logic             ovf_ff  [0:QW];

   logic [DEN_W-1:0] rem_in  [1:QW];
   logic [QW-1:0]    numq_in [1:QW];
   logic [DEN_W:0]   trial   [1:QW];
   logic [DEN_W:0]   diff    [1:QW];
   logic             ge      [1:QW];

   assign hi_ext  = CMP_W'(num[NUM_W-1:QW]);
   assign den_ext = CMP_W'(den);

   // one quotient bit per stage, restoring
   always_comb begin
      for (int k = 1; k <= QW; k++) begin
         trial[k]   = {rem_ff[k-1], numq_ff[k-1][QW-1]};
         diff[k]    = trial[k] - {1'b0, den_ff[k-1]};
         ge[k]      = trial[k] >= {1'b0, den_ff[k-1]};
         rem_in[k]  = ge[k] ? diff[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
         numq_in[k] = {numq_ff[k-1][QW-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= hi_ext[DEN_W-1:0];
         numq_ff[0] <= num[QW-1:0];
         den_ff[0]  <= den;
         ovf_ff[0]  <= hi_ext >= den_ext;
         for (int k = 1; k <= QW; k++) begin
            rem_ff[k]  <= rem_in[k];
            numq_ff[k] <= numq_in[k];
            ovf_ff[k]  <= ovf_ff[k-1];
         end
         for (int k = 1; k < QW; k++) begin
            den_ff[k] <= den_ff[k-1];
         end
      end
   end

   assign quo = ovf_ff[QW] ? {QW{1'b1}} : numq_ff[QW];

endmodule

`default_nettype wire
